// File: rtl/core/mirror_reflection_point_assert.svh
// ----------------------------------------------------------------------------
// Mirror reflection point assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MIRROR_REFLECTION_POINT_ASSERT_SVH
`define MIRROR_REFLECTION_POINT_ASSERT_SVH

// Check that is switched off while reset is held.
`define MRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that also holds across reset.
`define MRP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/core/mrp_pkg.sv
// ----------------------------------------------------------------------------
// Mirror reflection point package
// Shared constants and the per-item control flags.
// ----------------------------------------------------------------------------
package mrp_pkg;

    // Width of the normal threshold register.
    localparam int THR_W = 31;

    // Control flags that travel with each item down the pipeline.
    typedef struct packed {
        logic       degen;  // normal unusable, eye point is returned
        logic [2:0] qneg;   // sign of the correction term per axis
    } t_flags;

endpackage

// File: rtl/core/mirror_reflection_point.sv
// ----------------------------------------------------------------------------
// Mirror reflection point
// Reflects the eye point about the line through the mirror point along the
// mirror normal, giving a point on the reflected ray, in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one item per transfer: normal N, eye A and
// mirror point M, each signed with FRAC_BITS fraction bits. A transfer
// happens on a rising edge with i_valid high and o_stall low.
// The output channel gives R = 2M - A + round(2 N (A-M).N / |N|^2) with the
// degenerate and saturated flags; a transfer happens when o_valid is high
// and i_stall is low.
// There are seven front end stages, one restoring divider stage per quotient
// bit (COORD_WIDTH + 2), and the output register. One item can be accepted in
// every cycle unless o_stall is high. The user must write the threshold by
// i_cfg_wr_en / i_cfg_wr_data only while idle; the block does not enforce it.
// Reset clears all valid bits and loads the threshold with 0.001 in the
// coordinate format. When the receiver stalls, the pipeline keeps filling
// its empty stages and holds o_stall high only once every stage is full.
// ----------------------------------------------------------------------------
module mirror_reflection_point
    import mrp_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port for the normal threshold.
    input  logic                   i_cfg_wr_en,
    input  logic [THR_W-1:0]       i_cfg_wr_data,
    // Input channel.
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [COORD_WIDTH-1:0] i_normal_x,
    input  logic [COORD_WIDTH-1:0] i_normal_y,
    input  logic [COORD_WIDTH-1:0] i_normal_z,
    input  logic [COORD_WIDTH-1:0] i_eye_x,
    input  logic [COORD_WIDTH-1:0] i_eye_y,
    input  logic [COORD_WIDTH-1:0] i_eye_z,
    input  logic [COORD_WIDTH-1:0] i_hit_x,
    input  logic [COORD_WIDTH-1:0] i_hit_y,
    input  logic [COORD_WIDTH-1:0] i_hit_z,
    // Output channel.
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [COORD_WIDTH-1:0] o_reflected_x,
    output logic [COORD_WIDTH-1:0] o_reflected_y,
    output logic [COORD_WIDTH-1:0] o_reflected_z,
    output logic                   o_degenerate,
    output logic                   o_saturated
);

    localparam int W  = COORD_WIDTH;
    localparam int NW = 3 * W + 3;
    localparam int BW = W + 2;

    // Reset threshold: 0.001 rounded to the nearest fixed-point step.
    localparam logic [THR_W-1:0] THR_RESET =
        THR_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

    logic [THR_W-1:0] r_normal_threshold;
    logic [THR_W-1:0] n_normal_threshold;

    assign n_normal_threshold = i_cfg_wr_en ? i_cfg_wr_data : r_normal_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_threshold <= THR_RESET;
        end else begin
            r_normal_threshold <= n_normal_threshold;
        end
    end

    // Group the coordinates per vector, x in lane 0.
    logic [2:0][W-1:0] w_n;
    logic [2:0][W-1:0] w_a;
    logic [2:0][W-1:0] w_m;

    assign w_n = {i_normal_z, i_normal_y, i_normal_x};
    assign w_a = {i_eye_z, i_eye_y, i_eye_x};
    assign w_m = {i_hit_z, i_hit_y, i_hit_x};

    // Front end to divider.
    logic               w_p_valid;
    logic               w_p_stall;
    logic [2:0][NW-1:0] w_p_dvd;
    logic [2*W:0]       w_p_dvs;
    logic [2:0][BW-1:0] w_p_base;
    t_flags             w_p_flags;

    mrp_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_thr   (r_normal_threshold),
        .i_n     (w_n),
        .i_a     (w_a),
        .i_m     (w_m),
        .o_valid (w_p_valid),
        .i_stall (w_p_stall),
        .o_dvd   (w_p_dvd),
        .o_dvs   (w_p_dvs),
        .o_base  (w_p_base),
        .o_flags (w_p_flags)
    );

    // Divider to output stage.
    logic               w_d_valid;
    logic               w_d_stall;
    logic [2:0][BW-1:0] w_d_quo;
    logic [2:0][BW-1:0] w_d_base;
    t_flags             w_d_flags;

    mrp_div #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_p_valid),
        .o_stall (w_p_stall),
        .i_dvd   (w_p_dvd),
        .i_dvs   (w_p_dvs),
        .i_base  (w_p_base),
        .i_flags (w_p_flags),
        .o_valid (w_d_valid),
        .i_stall (w_d_stall),
        .o_quo   (w_d_quo),
        .o_base  (w_d_base),
        .o_flags (w_d_flags)
    );

    logic [2:0][W-1:0] w_res;

    mrp_post #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_stall (w_d_stall),
        .i_quo   (w_d_quo),
        .i_base  (w_d_base),
        .i_flags (w_d_flags),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (w_res),
        .o_degen (o_degenerate),
        .o_sat   (o_saturated)
    );

    assign o_reflected_x = w_res[0];
    assign o_reflected_y = w_res[1];
    assign o_reflected_z = w_res[2];

    // A degenerate item returns the eye point, which always fits.
    // The input side can only be held off when every stage is full and the
    // output is stalled. Reset empties the pipeline.
`include "mirror_reflection_point_assert.svh"
    `MRP_ASSERT(a_degen_no_sat, o_valid && o_degenerate |-> !o_saturated, "degenerate item saturated")
    `MRP_ASSERT(a_stall_full, o_stall |-> o_valid && i_stall, "input stalled with room in pipeline")
    `MRP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid, "output valid right after reset")

endmodule

// File: rtl/core/mrp_prep.sv
// ----------------------------------------------------------------------------
// Mirror reflection point front end
// Seven stages: differences, split products, dot product, |N|^2 and the
// dividend and divisor of the per-axis correction.
// ----------------------------------------------------------------------------
module mrp_prep
    import mrp_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [THR_W-1:0]                      i_thr,
    input  logic [2:0][COORD_WIDTH-1:0]           i_n,
    input  logic [2:0][COORD_WIDTH-1:0]           i_a,
    input  logic [2:0][COORD_WIDTH-1:0]           i_m,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [2:0][3*COORD_WIDTH+2:0]         o_dvd,
    output logic [2*COORD_WIDTH:0]                o_dvs,
    output logic [2:0][COORD_WIDTH+1:0]           o_base,
    output t_flags                                o_flags
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int H   = (W + 1) / 2;
    localparam int HH  = W - H;
    localparam int PW  = 2 * W;
    localparam int SW  = 2 * W + 1;
    localparam int NW  = 3 * W + 3;
    localparam int DSW = 2 * W + 1;
    localparam int BW  = W + 2;
    localparam int TW  = (W > THR_W) ? W : THR_W;
    localparam int NS  = 7;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    // Load enables ripple back from the output: a stage loads when it is
    // empty or its content moves on.
    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: differences, magnitudes, threshold test, base point.
    logic [2:0][DW-1:0] w_d;
    logic [2:0][DW-1:0] w_dmag;
    logic [2:0][W-1:0]  w_nmag;
    logic [2:0]         w_big;
    logic [2:0]         w_pneg;
    logic [2:0][BW-1:0] w_aext;
    logic [2:0][BW-1:0] w_2m;
    logic [2:0][BW-1:0] w_base;
    logic               w_degen;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i]    = {i_a[i][W-1], i_a[i]} - {i_m[i][W-1], i_m[i]};
            w_dmag[i] = w_d[i][DW-1] ? (~w_d[i] + DW'(1)) : w_d[i];
            w_nmag[i] = i_n[i][W-1] ? (~i_n[i] + W'(1)) : i_n[i];
            w_big[i]  = TW'(w_nmag[i]) >= TW'(i_thr);
            w_pneg[i] = w_d[i][DW-1] ^ i_n[i][W-1];
            w_aext[i] = {{2{i_a[i][W-1]}}, i_a[i]};
            w_2m[i]   = {i_m[i][W-1], i_m[i], 1'b0};
        end
        w_degen = !(|w_big) || (i_n == '0);
        for (int i = 0; i < 3; i++) begin
            w_base[i] = w_degen ? w_aext[i] : (w_2m[i] - w_aext[i]);
        end
    end

    logic [2:0][DW-1:0] r1_dmag;
    logic [2:0][W-1:0]  r1_nmag;
    logic [2:0]         r1_pneg;
    logic [2:0]         r1_nneg;
    logic [2:0][BW-1:0] r1_base;
    logic               r1_degen;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_dmag  <= w_dmag;
            r1_nmag  <= w_nmag;
            r1_pneg  <= w_pneg;
            r1_nneg  <= {i_n[2][W-1], i_n[1][W-1], i_n[0][W-1]};
            r1_base  <= w_base;
            r1_degen <= w_degen;
        end
    end

    // Stage 2: partial products against the low and high halves of |n|.
    logic [2:0][DW+H-1:0]  r2_pl;
    logic [2:0][DW+HH-1:0] r2_ph;
    logic [2:0][W+H-1:0]   r2_ql;
    logic [2:0][W+HH-1:0]  r2_qh;
    logic [2:0][W-1:0]     r2_nmag;
    logic [2:0]            r2_pneg;
    logic [2:0]            r2_nneg;
    logic [2:0][BW-1:0]    r2_base;
    logic                  r2_degen;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r2_pl[i] <= {{H{1'b0}}, r1_dmag[i]} * {{DW{1'b0}}, r1_nmag[i][H-1:0]};
                r2_ph[i] <= {{HH{1'b0}}, r1_dmag[i]} * {{DW{1'b0}}, r1_nmag[i][W-1:H]};
                r2_ql[i] <= {{H{1'b0}}, r1_nmag[i]} * {{W{1'b0}}, r1_nmag[i][H-1:0]};
                r2_qh[i] <= {{HH{1'b0}}, r1_nmag[i]} * {{W{1'b0}}, r1_nmag[i][W-1:H]};
            end
            r2_nmag  <= r1_nmag;
            r2_pneg  <= r1_pneg;
            r2_nneg  <= r1_nneg;
            r2_base  <= r1_base;
            r2_degen <= r1_degen;
        end
    end

    // Stage 3: join the halves into |d_i||n_i| and n_i^2.
    logic [2:0][PW-1:0] r3_p;
    logic [2:0][PW-1:0] r3_nsq;
    logic [2:0][W-1:0]  r3_nmag;
    logic [2:0]         r3_pneg;
    logic [2:0]         r3_nneg;
    logic [2:0][BW-1:0] r3_base;
    logic               r3_degen;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_p[i]   <= PW'(r2_pl[i]) + (PW'(r2_ph[i]) << H);
                r3_nsq[i] <= PW'(r2_ql[i]) + (PW'(r2_qh[i]) << H);
            end
            r3_nmag  <= r2_nmag;
            r3_pneg  <= r2_pneg;
            r3_nneg  <= r2_nneg;
            r3_base  <= r2_base;
            r3_degen <= r2_degen;
        end
    end

    // Stage 4: positive and negative parts of the dot product, and |N|^2.
    logic [SW-1:0] w_pos;
    logic [SW-1:0] w_neg;
    logic [PW-1:0] w_nn;

    always_comb begin
        w_pos = '0;
        w_neg = '0;
        w_nn  = '0;
        for (int i = 0; i < 3; i++) begin
            if (r3_pneg[i]) begin
                w_neg = w_neg + SW'(r3_p[i]);
            end else begin
                w_pos = w_pos + SW'(r3_p[i]);
            end
            w_nn = w_nn + r3_nsq[i];
        end
    end

    logic [SW-1:0]      r4_pos;
    logic [SW-1:0]      r4_neg;
    logic [PW-1:0]      r4_nn;
    logic [2:0][W-1:0]  r4_nmag;
    logic [2:0]         r4_nneg;
    logic [2:0][BW-1:0] r4_base;
    logic               r4_degen;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_pos   <= w_pos;
            r4_neg   <= w_neg;
            r4_nn    <= w_nn;
            r4_nmag  <= r3_nmag;
            r4_nneg  <= r3_nneg;
            r4_base  <= r3_base;
            r4_degen <= r3_degen;
        end
    end

    // Stage 5: magnitude and sign of the dot product.
    logic w_dneg;
    assign w_dneg = r4_neg > r4_pos;

    logic [SW-1:0]      r5_dotm;
    logic [PW-1:0]      r5_nn;
    logic [2:0][W-1:0]  r5_nmag;
    logic [2:0][BW-1:0] r5_base;
    t_flags             r5_flags;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_dotm        <= w_dneg ? (r4_neg - r4_pos) : (r4_pos - r4_neg);
            r5_nn          <= r4_nn;
            r5_nmag        <= r4_nmag;
            r5_base        <= r4_base;
            r5_flags.degen <= r4_degen;
            r5_flags.qneg  <= r4_nneg ^ {3{w_dneg}};
        end
    end

    // Stage 6: |dot||n_i| as two partial products per axis.
    logic [2:0][SW+H-1:0]  r6_tl;
    logic [2:0][SW+HH-1:0] r6_th;
    logic [PW-1:0]         r6_nn;
    logic [2:0][BW-1:0]    r6_base;
    t_flags                r6_flags;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int i = 0; i < 3; i++) begin
                r6_tl[i] <= {{H{1'b0}}, r5_dotm} * {{SW{1'b0}}, r5_nmag[i][H-1:0]};
                r6_th[i] <= {{HH{1'b0}}, r5_dotm} * {{SW{1'b0}}, r5_nmag[i][W-1:H]};
            end
            r6_nn    <= r5_nn;
            r6_base  <= r5_base;
            r6_flags <= r5_flags;
        end
    end

    // Stage 7: dividend 4|n_i||dot| + |N|^2 and divisor 2|N|^2, which give
    // the rounded quotient with ties away from zero.
    logic [2:0][NW-1:0] r7_dvd;
    logic [DSW-1:0]     r7_dvs;
    logic [2:0][BW-1:0] r7_base;
    t_flags             r7_flags;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int i = 0; i < 3; i++) begin
                r7_dvd[i] <= ((NW'(r6_tl[i]) + (NW'(r6_th[i]) << H)) << 2) + NW'(r6_nn);
            end
            r7_dvs   <= {r6_nn, 1'b0};
            r7_base  <= r6_base;
            r7_flags <= r6_flags;
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[NS-1];
    assign o_dvd   = r7_dvd;
    assign o_dvs   = r7_dvs;
    assign o_base  = r7_base;
    assign o_flags = r7_flags;

endmodule

// File: rtl/core/mrp_div.sv
// ----------------------------------------------------------------------------
// Mirror reflection point divider
// Pipelined restoring division, one quotient bit per stage, three lanes.
// ----------------------------------------------------------------------------
module mrp_div
    import mrp_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [2:0][3*COORD_WIDTH+2:0]         i_dvd,
    input  logic [2*COORD_WIDTH:0]                i_dvs,
    input  logic [2:0][COORD_WIDTH+1:0]           i_base,
    input  t_flags                                i_flags,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [2:0][COORD_WIDTH+1:0]           o_quo,
    output logic [2:0][COORD_WIDTH+1:0]           o_base,
    output t_flags                                o_flags
);

    localparam int W   = COORD_WIDTH;
    localparam int NW  = 3 * W + 3;
    localparam int DSW = 2 * W + 1;
    localparam int BW  = W + 2;
    localparam int QW  = W + 2;

    logic [QW-1:0] r_v;
    logic [QW-1:0] w_en;

    always_comb begin
        w_en[QW-1] = !r_v[QW-1] || !i_stall;
        for (int k = QW - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < QW; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    logic [2:0][NW-1:0] r_rem  [QW];
    logic [2:0][QW-1:0] r_q    [QW];
    logic [DSW-1:0]     r_dvs  [QW];
    logic [2:0][BW-1:0] r_base [QW];
    t_flags             r_flags[QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [2:0][NW-1:0] w_rem_in;
        logic [2:0][QW-1:0] w_q_in;
        logic [DSW-1:0]     w_dvs_in;
        logic [2:0][BW-1:0] w_base_in;
        t_flags             w_flags_in;
        logic [NW:0]        w_sub;
        logic [2:0][NW:0]   w_trial;

        if (s == 0) begin : g_first
            assign w_rem_in   = i_dvd;
            assign w_q_in     = '0;
            assign w_dvs_in   = i_dvs;
            assign w_base_in  = i_base;
            assign w_flags_in = i_flags;
        end else begin : g_next
            assign w_rem_in   = r_rem[s-1];
            assign w_q_in     = r_q[s-1];
            assign w_dvs_in   = r_dvs[s-1];
            assign w_base_in  = r_base[s-1];
            assign w_flags_in = r_flags[s-1];
        end

        // Divisor aligned to the quotient bit of this stage.
        assign w_sub = (NW + 1)'(w_dvs_in) << (QW - 1 - s);

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_trial[i] = {1'b0, w_rem_in[i]} - w_sub;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[s][i] <= w_trial[i][NW] ? w_rem_in[i] : w_trial[i][NW-1:0];
                    r_q[s][i]   <= {w_q_in[i][QW-2:0], !w_trial[i][NW]};
                end
                r_dvs[s]   <= w_dvs_in;
                r_base[s]  <= w_base_in;
                r_flags[s] <= w_flags_in;
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[QW-1];
    assign o_quo   = r_q[QW-1];
    assign o_base  = r_base[QW-1];
    assign o_flags = r_flags[QW-1];

endmodule

// File: rtl/core/mrp_post.sv
// ----------------------------------------------------------------------------
// Mirror reflection point output stage
// Applies the signed correction, saturates and holds the result.
// ----------------------------------------------------------------------------
module mrp_post
    import mrp_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [2:0][COORD_WIDTH+1:0]           i_quo,
    input  logic [2:0][COORD_WIDTH+1:0]           i_base,
    input  t_flags                                i_flags,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [2:0][COORD_WIDTH-1:0]           o_res,
    output logic                                  o_degen,
    output logic                                  o_sat
);

    localparam int W  = COORD_WIDTH;
    localparam int RW = W + 4;

    logic [2:0][RW-1:0] w_q;
    logic [2:0][RW-1:0] w_r;
    logic [2:0]         w_over;
    logic [2:0][W-1:0]  w_res;
    logic               w_en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i_flags.degen) begin
                w_q[i] = '0;
            end else if (i_flags.qneg[i]) begin
                w_q[i] = ~RW'(i_quo[i]) + RW'(1);
            end else begin
                w_q[i] = RW'(i_quo[i]);
            end
            w_r[i]    = {{2{i_base[i][W+1]}}, i_base[i]} + w_q[i];
            w_over[i] = !((&w_r[i][RW-1:W-1]) || !(|w_r[i][RW-1:W-1]));
            if (!w_over[i]) begin
                w_res[i] = w_r[i][W-1:0];
            end else if (w_r[i][RW-1]) begin
                w_res[i] = {1'b1, {(W-1){1'b0}}};
            end else begin
                w_res[i] = {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    logic              r_v;
    logic [2:0][W-1:0] r_res;
    logic              r_degen;
    logic              r_sat;

    assign w_en = !r_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res   <= w_res;
            r_degen <= i_flags.degen;
            r_sat   <= |w_over;
        end
    end

    assign o_stall = !w_en;
    assign o_valid = r_v;
    assign o_res   = r_res;
    assign o_degen = r_degen;
    assign o_sat   = r_sat;

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Mirror reflection point testbench
// Drives normal, eye and mirror points through the block with random idling
// on both channels. Every output transfer is checked field by field against a
// typed-in result or a predictor that reflects the eye point about the line
// through the mirror point along the normal, with the same rounding and
// saturation. The normal threshold changes per phase, extremes included.
// ----------------------------------------------------------------------------
module testbench;
    import mrp_pkg::*;

    localparam int CW        = 32;
    localparam int LATENCY   = CW + 10;
    localparam int MAX_CYCLE = 2000000;
    localparam int N_RANDOM  = 1550;

    // Named threshold settings used between phases.
    localparam logic [THR_W-1:0] THR_RESET = 66;
    localparam logic [THR_W-1:0] THR_ZERO  = 0;
    localparam logic [THR_W-1:0] THR_MAX   = 31'h7fff_ffff;
    localparam logic [THR_W-1:0] THR_ONE   = 31'h0001_0000;

    typedef struct packed {
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic signed [CW-1:0] rz;
        logic                 degen;
        logic                 sat;
    } t_reflection;

    typedef struct {
        logic signed [CW-1:0] n[3];
        logic signed [CW-1:0] a[3];
        logic signed [CW-1:0] m[3];
        bit                   known;  // expected result typed in below
        t_reflection          res;
    } t_query;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [THR_W-1:0]     i_cfg_wr_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [CW-1:0]        i_normal_x = '0, i_normal_y = '0, i_normal_z = '0;
    logic [CW-1:0]        i_eye_x = '0, i_eye_y = '0, i_eye_z = '0;
    logic [CW-1:0]        i_hit_x = '0, i_hit_y = '0, i_hit_z = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [CW-1:0]        o_reflected_x, o_reflected_y, o_reflected_z;
    logic                 o_degenerate, o_saturated;

    mirror_reflection_point dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_normal_x(i_normal_x), .i_normal_y(i_normal_y), .i_normal_z(i_normal_z),
        .i_eye_x(i_eye_x), .i_eye_y(i_eye_y), .i_eye_z(i_eye_z),
        .i_hit_x(i_hit_x), .i_hit_y(i_hit_y), .i_hit_z(i_hit_z),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_reflected_x(o_reflected_x), .o_reflected_y(o_reflected_y),
        .o_reflected_z(o_reflected_z),
        .o_degenerate(o_degenerate), .o_saturated(o_saturated)
    );

    always #1 i_clk = ~i_clk;

    // Predictor copy of the threshold register.
    logic [THR_W-1:0] threshold_model = THR_RESET;
    t_reflection      pending_reflections[$];
    int               mismatches = 0;
    int               cycle = 0;
    bit               quiet = 1'b0;   // no idling in the last part of the run

    // Reflect A about the line through M along N. The dot product and |N|^2
    // are exact in 192 bits; only the correction term q is rounded, to
    // nearest with ties away from zero, then each axis saturates.
    function automatic t_reflection reflect_point(t_query t, logic [THR_W-1:0] thr);
        t_reflection       r;
        logic signed [191:0] dot, nn, d, num, q, v;
        logic [191:0]      mq, mn;
        logic signed [191:0] hi, lo;
        bit                any_big, sat;
        logic signed [CW-1:0] out[3];
        dot = 0;
        nn = 0;
        any_big = 1'b0;
        sat = 1'b0;
        hi = (192'sd1 <<< (CW - 1)) - 1;
        lo = -hi - 1;
        for (int i = 0; i < 3; i++) begin
            v = t.n[i];
            if ((v < 0 ? -v : v) >= $signed({161'd0, thr})) any_big = 1'b1;
            d = 192'(t.a[i]) - 192'(t.m[i]);
            dot += d * 192'(t.n[i]);
            nn += 192'(t.n[i]) * 192'(t.n[i]);
        end
        if (!any_big || nn == 0) begin
            r.rx = t.a[0];
            r.ry = t.a[1];
            r.rz = t.a[2];
            r.degen = 1'b1;
            r.sat = 1'b0;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            num = dot * 192'(t.n[i]);
            mn = num < 0 ? -num : num;
            mq = (4 * mn + nn) / (2 * nn);
            q = num < 0 ? -$signed(mq) : $signed(mq);
            v = 2 * 192'(t.m[i]) - 192'(t.a[i]) + q;
            if (v > hi) begin
                v = hi;
                sat = 1'b1;
            end
            if (v < lo) begin
                v = lo;
                sat = 1'b1;
            end
            out[i] = v[CW-1:0];
        end
        r.rx = out[0];
        r.ry = out[1];
        r.rz = out[2];
        r.degen = 1'b0;
        r.sat = sat;
        return r;
    endfunction

    // Directed stimulus. Rows with known set carry a result read straight
    // off the geometry; the others go through the predictor.
    localparam logic signed [CW-1:0] MX = 32'sh7fff_ffff;
    localparam logic signed [CW-1:0] MN = 32'sh8000_0000;
    localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;

    function automatic t_query mk(logic signed [CW-1:0] nx, ny, nz, ax, ay, az,
                                  mx, my, mz);
        t_query t;
        t.n = '{nx, ny, nz};
        t.a = '{ax, ay, az};
        t.m = '{mx, my, mz};
        t.known = 1'b0;
        t.res = '0;
        return t;
    endfunction

    function automatic t_query mk_known(t_query t, logic signed [CW-1:0] rx, ry, rz,
                                        logic dg, logic st);
        t.known = 1'b1;
        t.res = '{rx, ry, rz, dg, st};
        return t;
    endfunction

    t_query directed[$];

    task automatic build_directed();
        // Zero normal: the eye point comes back, degenerate.
        directed.push_back(mk_known(mk(0, 0, 0, ONE, -ONE, 5, 7, 8, 9),
                                    ONE, -ONE, 5, 1'b1, 1'b0));
        // All normal components just under the reset threshold.
        directed.push_back(mk_known(mk(65, -65, 65, MX, MN, 3, 0, 0, 0),
                                    MX, MN, 3, 1'b1, 1'b0));
        // Exactly at the threshold is usable.
        directed.push_back(mk(66, 0, 0, ONE, ONE, ONE, 0, 0, 0));
        // Eye on the line: R equals A.
        directed.push_back(mk_known(mk(ONE, 0, 0, 3 * ONE, 0, 0, 0, 0, 0),
                                    3 * ONE, 0, 0, 1'b0, 1'b0));
        // Eye off the line along x: y and z flip about M.
        directed.push_back(mk_known(mk(ONE, 0, 0, ONE, 2 * ONE, -ONE, 0, 0, 0),
                                    ONE, -2 * ONE, ONE, 1'b0, 1'b0));
        // Overflow in both directions.
        directed.push_back(mk_known(mk(0, ONE, 0, MN, 0, MN, MX, 0, MX),
                                    MX, 0, MX, 1'b0, 1'b1));
        directed.push_back(mk_known(mk(0, 0, ONE, MX, MX, 0, MN, MN, 0),
                                    MN, MN, 0, 1'b0, 1'b1));
        directed.push_back(mk(MN, MN, MN, MX, MX, MX, MN, MN, MN));
        directed.push_back(mk(MX, MX, MX, MN, MN, MN, MX, MX, MX));
        directed.push_back(mk(MN, MX, 1, -1, MX, MN, 1, -1, 0));
        directed.push_back(mk(1, -1, MN, 7, -7, MX, -3, MN, MX));
        directed.push_back(mk(3, 5, -7, ONE, -ONE, 2, -5, 11, 13));
        directed.push_back(mk(-ONE, ONE, ONE, 1, 2, 3, 4, 5, 6));
        // Ties in the rounding of q are likely with small odd values.
        directed.push_back(mk(ONE, ONE, 0, 1, 0, 0, 0, 0, 0));
        directed.push_back(mk(-ONE, ONE, 0, -1, 0, 0, 0, 0, 0));
    endtask

    // Random query: mostly moderate geometry, sometimes full range, and some
    // normals near the threshold so both sides of the compare are hit.
    function automatic logic signed [CW-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $signed($urandom_range(0, 200)) - 100;
            2: return ($urandom_range(0, 1) ? MX : MN) - $signed($urandom_range(0, 3));
            default: return $signed($urandom() & 32'h00ff_ffff) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic t_query rnd_query(logic [THR_W-1:0] thr);
        t_query t;
        t = mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
               rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        if ($urandom_range(0, 7) == 0) begin
            for (int i = 0; i < 3; i++) begin
                t.n[i] = $signed({1'b0, thr}) - 2 + $signed($urandom_range(0, 3));
                if ($urandom_range(0, 1)) t.n[i] = -t.n[i];
            end
        end
        return t;
    endfunction

    // Send one query, with a random idle burst before it when allowed.
    task automatic send_query(t_query t);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_normal_x, i_normal_y, i_normal_z} <= {t.n[0], t.n[1], t.n[2]};
        {i_eye_x, i_eye_y, i_eye_z} <= {t.a[0], t.a[1], t.a[2]};
        {i_hit_x, i_hit_y, i_hit_z} <= {t.m[0], t.m[1], t.m[2]};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // Transfer happened at this edge; queue what it should produce.
        pending_reflections.push_back(t.known ? t.res : reflect_point(t, threshold_model));
    endtask

    // Wait for the pipe to drain, then write the threshold.
    task automatic set_threshold(logic [THR_W-1:0] v);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reflections.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        threshold_model = v;
    endtask

    // Receiver: random stall bursts, then check each transfer.
    always @(posedge i_clk) begin
        t_reflection got, exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_reflected_x, o_reflected_y, o_reflected_z, o_degenerate,
                    o_saturated};
            if (pending_reflections.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end else begin
                exp_r = pending_reflections.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected x=%h y=%h z=%h dg=%b sat=%b, ",
                                  "got x=%h y=%h z=%h dg=%b sat=%b"},
                                 exp_r.rx, exp_r.ry, exp_r.rz, exp_r.degen, exp_r.sat,
                                 got.rx, got.ry, got.rz, got.degen, got.sat);
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("** mirror_reflection_point: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [THR_W-1:0] phase_thr[4];
        build_directed();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send_query(directed[k]);
        // Walk through several threshold settings, extremes included.
        phase_thr = '{THR_ZERO, THR_MAX, THR_ONE, THR_RESET};
        for (int p = 0; p < 4; p++) begin
            set_threshold(phase_thr[p]);
            if (phase_thr[p] == THR_ZERO)
                send_query(mk_known(mk(0, 0, 0, 1, 2, 3, 4, 5, 6), 1, 2, 3, 1'b1, 1'b0));
            for (int k = 0; k < N_RANDOM / 4; k++) begin
                if (p == 3 && k > N_RANDOM / 4 - 100) quiet = 1'b1;
                send_query(rnd_query(threshold_model));
            end
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reflections.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatches == 0 && pending_reflections.size() == 0) begin
            $display("** mirror_reflection_point: PASSED **");
        end else begin
            $display("** mirror_reflection_point: FAILED **");
        end
        $finish;
    end
endmodule
